>>> rtl/i2cm_pkg.sv
package i2cm_pkg;

	localparam int unsigned HALF_W = 16;
	localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;

	// input mode codes as carried on s_tuser
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_WDATA = 2'd2;

	// error codes shown on status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BUS  = 2'd1;
	localparam logic [1:0] ST_ACK  = 2'd2;

	// bus slots; a phase is slot * 4 + step
	localparam logic [2:0] SL_SEND = 3'd1;
	localparam logic [2:0] SL_ACK  = 3'd2;
	localparam logic [2:0] SL_RECV = 3'd3;
	localparam logic [2:0] SL_MACK = 3'd4;
	localparam logic [2:0] SL_STOP = 3'd5;

	localparam logic [1:0] STEP_LO  = 2'd0;
	localparam logic [1:0] STEP_HI  = 2'd1;
	localparam logic [1:0] STEP_SMP = 2'd2;

	// latched flag bits
	localparam int unsigned FL_READ = 0;
	localparam int unsigned FL_INT  = 1;
	localparam int unsigned FL_ADDR = 2;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_START,
		KIND_WDATA,
		KIND_NONE
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic        sda_in;
		logic        scl_in;
		logic        is_read;
		logic [6:0]  device_addr;
		logic        has_internal_addr;
		logic [7:0]  internal_addr;
		logic [7:0]  byte_count;
		logic [7:0]  write_byte;
	} item_t;

endpackage

>>> rtl/i2cm_front.sv
module i2cm_front import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      in_item;
	logic       push;

	always_comb begin
		in_item.sda_in            = s_tdata[0];
		in_item.scl_in            = s_tdata[1];
		in_item.is_read           = s_tdata[2];
		in_item.device_addr       = s_tdata[9:3];
		in_item.has_internal_addr = s_tdata[10];
		in_item.internal_addr     = s_tdata[18:11];
		in_item.byte_count        = s_tdata[26:19];
		in_item.write_byte        = s_tdata[34:27];
		case (s_tuser)
			MODE_TICK:  in_item.kind = KIND_TICK;
			MODE_START: in_item.kind = KIND_START;
			MODE_WDATA: in_item.kind = KIND_WDATA;
			default:    in_item.kind = KIND_NONE;
		endcase
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

>>> rtl/i2cm_back.sv
module i2cm_back import i2cm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [HALF_W-1:0] half_ticks,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic              m_tuser
);

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_START    = 5'd1,
		PH_WAIT     = 5'd2,
		PH_STOPFIN  = 5'd3,
		PH_SEND_LO  = 5'd4,
		PH_SEND_HI  = 5'd5,
		PH_SEND_SMP = 5'd6,
		PH_ACK_LO   = 5'd8,
		PH_ACK_HI   = 5'd9,
		PH_ACK_SMP  = 5'd10,
		PH_RECV_LO  = 5'd12,
		PH_RECV_HI  = 5'd13,
		PH_RECV_SMP = 5'd14,
		PH_MACK_LO  = 5'd16,
		PH_MACK_HI  = 5'd17,
		PH_MACK_SMP = 5'd18,
		PH_STOP_LO  = 5'd20,
		PH_STOP_HI  = 5'd21,
		PH_STOP_SMP = 5'd22
	} phase_t;

	phase_t            phase_q, n_phase;
	logic [2:0]        bit_q, n_bit;
	logic [7:0]        shift_q, n_shift;
	logic [7:0]        bytes_q, n_bytes;
	logic [HALF_W-1:0] delay_q, n_delay;
	logic [6:0]        dev_q, n_dev;
	logic [7:0]        int_q, n_int;
	logic [2:0]        flags_q, n_flags;
	logic [1:0]        err_q, n_err;
	logic              sda_q, n_sda;
	logic              o_done, o_rvalid;
	logic [7:0]        o_rbyte;
	logic [2:0]        slot, n_slot;
	logic [1:0]        step;
	logic              timer_run;
	logic [7:0]        recv_byte;
	logic              out_valid_q;
	logic [15:0]       out_data_q;
	logic              out_user_q;

	function automatic phase_t mk_phase(input logic [2:0] s, input logic [1:0] t);
		return phase_t'({s, t});
	endfunction

	assign slot      = phase_q[4:2];
	assign step      = phase_q[1:0];
	assign timer_run = (delay_q > 16'd1);
	assign recv_byte = {shift_q[6:0], q_item.sda_in};
	assign q_pop     = q_valid && (!out_valid_q || m_tready);

	always_comb begin
		n_phase  = phase_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_bytes  = bytes_q;
		n_delay  = delay_q;
		n_dev    = dev_q;
		n_int    = int_q;
		n_flags  = flags_q;
		n_err    = err_q;
		n_sda    = sda_q;
		o_done   = 1'b0;
		o_rvalid = 1'b0;
		o_rbyte  = 8'd0;
		case (q_item.kind)
			KIND_START: begin
				if (phase_q == PH_IDLE) begin
					n_flags = {1'b0, q_item.has_internal_addr, q_item.is_read};
					n_dev   = q_item.device_addr;
					n_int   = q_item.internal_addr;
					n_bytes = q_item.byte_count;
					n_err   = ST_OK;
					n_sda   = 1'b1;
					n_phase = PH_START;
				end
			end
			KIND_WDATA: begin
				if (phase_q == PH_WAIT) begin
					n_shift = q_item.write_byte;
					n_bit   = 3'd0;
					n_phase = PH_SEND_LO;
					n_delay = half_ticks;
				end
			end
			KIND_TICK: begin
				if (phase_q == PH_START) begin
					if (!(q_item.scl_in && q_item.sda_in)) begin
						n_err   = ST_BUS;
						n_phase = PH_IDLE;
						n_sda   = 1'b1;
						o_done  = 1'b1;
					end else begin
						n_shift = {dev_q, flags_q[FL_READ] && !flags_q[FL_INT]};
						n_bit   = 3'd0;
						n_sda   = 1'b0;
						n_phase = PH_SEND_LO;
						n_delay = half_ticks;
					end
				end else if (phase_q == PH_STOPFIN) begin
					if (timer_run) begin
						n_delay = delay_q - 16'd1;
					end else begin
						n_sda = 1'b1;
						if (err_q == ST_OK && flags_q[FL_READ] && !flags_q[FL_ADDR]) begin
							n_phase = PH_START;
						end else begin
							n_phase = PH_IDLE;
							o_done  = 1'b1;
						end
					end
				end else if (slot >= SL_SEND && slot <= SL_STOP) begin
					if (step == STEP_LO) begin
						if (timer_run) begin
							n_delay = delay_q - 16'd1;
						end else begin
							case (slot)
								SL_SEND: n_sda = shift_q[3'd7 - bit_q];
								SL_MACK: n_sda = (bytes_q == 8'd0);
								SL_STOP: n_sda = 1'b0;
								default: n_sda = 1'b1;
							endcase
							n_phase = mk_phase(slot, STEP_HI);
							n_delay = half_ticks;
						end
					end else if (step == STEP_HI) begin
						if (timer_run) begin
							n_delay = delay_q - 16'd1;
						end else begin
							n_phase = mk_phase(slot, STEP_SMP);
						end
					end else if (q_item.scl_in) begin
						n_slot  = SL_STOP;
						n_delay = half_ticks;
						case (slot)
							SL_SEND: begin
								if (q_item.sda_in != sda_q) begin
									// lost arbitration: release and end at once
									n_err   = ST_BUS;
									n_phase = PH_IDLE;
									n_sda   = 1'b1;
									o_done  = 1'b1;
								end else begin
									n_bit   = bit_q + 3'd1;
									n_slot  = (n_bit == 3'd0) ? SL_ACK : SL_SEND;
									n_phase = mk_phase(n_slot, STEP_LO);
								end
							end
							SL_ACK: begin
								if (q_item.sda_in) begin
									n_err = ST_ACK;
								end else if (!flags_q[FL_ADDR]) begin
									n_flags[FL_ADDR] = 1'b1;
									if (flags_q[FL_INT]) begin
										n_shift = int_q;
										n_bit   = 3'd0;
										n_slot  = SL_SEND;
									end else if (flags_q[FL_READ]) begin
										if (bytes_q != 8'd0) begin
											n_bit  = 3'd0;
											n_slot = SL_RECV;
										end
									end else if (bytes_q != 8'd0) begin
										n_slot = 3'd0;
									end
								end else if (flags_q[FL_INT]) begin
									n_flags[FL_INT] = 1'b0;
									if (flags_q[FL_READ]) begin
										n_flags[FL_ADDR] = 1'b0;
									end else if (bytes_q != 8'd0) begin
										n_slot = 3'd0;
									end
								end else begin
									n_bytes = bytes_q - 8'd1;
									if (n_bytes != 8'd0) begin
										n_slot = 3'd0;
									end
								end
								// slot zero marks a wait for the next write byte
								if (n_slot == 3'd0) begin
									n_phase = PH_WAIT;
									n_sda   = 1'b1;
								end else begin
									n_phase = mk_phase(n_slot, STEP_LO);
								end
							end
							SL_RECV: begin
								n_shift = recv_byte;
								n_bit   = bit_q + 3'd1;
								if (n_bit == 3'd0) begin
									o_rvalid = 1'b1;
									o_rbyte  = recv_byte;
									n_bytes  = bytes_q - 8'd1;
									n_phase  = PH_MACK_LO;
								end else begin
									n_phase = PH_RECV_LO;
								end
							end
							SL_MACK: begin
								if (bytes_q != 8'd0) begin
									n_bit   = 3'd0;
									n_phase = PH_RECV_LO;
								end else begin
									n_phase = PH_STOP_LO;
								end
							end
							default: begin
								n_phase = PH_STOPFIN;
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase
		n_slot = n_phase[4:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			bytes_q     <= 8'd0;
			delay_q     <= '0;
			dev_q       <= 7'd0;
			int_q       <= 8'd0;
			flags_q     <= 3'd0;
			err_q       <= ST_OK;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
			out_data_q  <= 16'd0;
			out_user_q  <= 1'b0;
		end else if (q_pop) begin
			phase_q     <= n_phase;
			bit_q       <= n_bit;
			shift_q     <= n_shift;
			bytes_q     <= n_bytes;
			delay_q     <= n_delay;
			dev_q       <= n_dev;
			int_q       <= n_int;
			flags_q     <= n_flags;
			err_q       <= n_err;
			sda_q       <= n_sda;
			out_valid_q <= 1'b1;
			out_data_q  <= {1'b0, n_err, o_done, o_rbyte, (n_phase == PH_WAIT),
				(n_phase != PH_IDLE), n_sda,
				!(n_slot >= SL_SEND && n_phase[1:0] == STEP_HI)};
			out_user_q  <= o_rvalid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> rtl/i2c_master_transaction_engine.sv
// Path: an item is queued, then its result is registered for the master side.
// Throughput: one item per cycle while m_tready takes results; the engine updates
// its bus state item by item, and a two-entry queue separates it from the input.
// Reset: arst_n is asynchronous and active low; it clears the queue, the output
// register and the engine (bus idle, both lines released) and sets
// half_period_ticks to 100.
module i2c_master_transaction_engine import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write: half_period_ticks
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata, low bit first: sda_in[0], scl_in[1], is_read[2], device_addr[9:3],
	// has_internal_addr[10], internal_addr[18:11], byte_count[26:19],
	// write_byte[34:27], zero fill[39:35]
	input  logic [39:0] s_tdata,
	// tuser: mode[1:0]
	input  logic [1:0]  s_tuser,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata, low bit first: scl_out[0], sda_out[1], busy_res[2], data_request[3],
	// read_byte[11:4], done_res[12], status[14:13], zero fill[15]
	output logic [15:0] m_tdata,
	// tuser: read_valid[0]
	output logic        m_tuser
);

	logic [HALF_W-1:0] half_q;
	logic              q_valid;
	logic              q_pop;
	item_t             q_item;

	// Hold the half-period reload; the user must write it only while the engine is idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_valid) begin
			half_q <= cfg_data;
		end
	end

	// Front: decode the mode into an item kind and queue the item.
	i2cm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Back: advance the bus state one item at a time and register each result.
	i2cm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.half_ticks (half_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

`ifndef SYNTHESIS
	// A finished transaction must show the bus as no longer busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> !m_tdata[2])
		else $error("done reported while still busy");

	// A write byte is only requested inside a transaction.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2])
		else $error("data request outside a transaction");

	// SCL is only pulled low inside a transaction.
	a_scl_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2])
		else $error("SCL driven low while idle");

	// A received byte is always followed by the master ack, so the bus stays busy.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[2] && !m_tdata[12])
		else $error("read byte delivered outside a transaction");
`endif

endmodule
